// ===== hdl/mtt_pkg.sv =====
package mtt_pkg;

  // field widths fixed by the interface
  localparam int unsigned CYCLE_W    = 48;
  localparam int unsigned COST_W     = 48;
  localparam int unsigned INTERVAL_W = 40;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned BENEFIT_W  = 63;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;

  // internal benefit width: two 49-bit products summed, less a 48-bit cost
  localparam int unsigned BEN_W      = 50;

  // queue depth between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL        = 2'd0,
    REG_DIRTY_GAP       = 2'd1,
    REG_CLEAN_GAP       = 2'd2,
    REG_START_THRESHOLD = 2'd3
  } reg_idx_t;

  // command codes on the input channel
  typedef enum logic {
    CMD_COMPLETE = 1'b0,
    CMD_ISSUE    = 1'b1
  } cmd_t;

  // item classes after the front
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_COUNT = 2'd1,
    EV_ISSUE = 2'd2
  } ev_kind_t;

  // miss counter select: {fast, dirty}
  typedef enum logic [1:0] {
    CNT_SLOW_CLEAN = 2'd0,
    CNT_SLOW_DIRTY = 2'd1,
    CNT_FAST_CLEAN = 2'd2,
    CNT_FAST_DIRTY = 2'd3
  } cnt_sel_t;

  // last tuning action
  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_INC  = 2'd1,
    ACT_DEC  = 2'd2
  } act_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_MUL,
    BK_SUM,
    BK_COST,
    BK_ADJ
  } bk_state_t;

  // classified item as held in the queue
  typedef struct packed {
    ev_kind_t            kind;
    cnt_sel_t            sel;
    logic [CYCLE_W-1:0]  cycle_now;
    logic [COST_W-1:0]   cost;
  } ev_t;

  // tuning configuration seen by the back end
  typedef struct packed {
    logic [INTERVAL_W-1:0]   interval;
    logic signed [GAP_W-1:0] dirty_gap;
    logic signed [GAP_W-1:0] clean_gap;
  } cfg_t;

endpackage

// ===== hdl/mtt_front.sv =====
module mtt_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     cmd,
  input  logic [47:0]              cycle_now,
  input  logic                     fast_media,
  input  logic                     row_hit,
  input  logic                     dirty_wb,
  input  logic                     was_migrated,
  input  logic [47:0]              migration_cost,
  input  logic                     q_full,
  output logic                     q_push,
  output mtt_pkg::ev_t             q_data
);
  import mtt_pkg::*;

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify the item for the back end
  always_comb begin
    q_data.cycle_now = cycle_now;
    q_data.cost      = migration_cost;
    q_data.sel       = cnt_sel_t'({fast_media, dirty_wb});
    case (cmd_t'(cmd))
      CMD_ISSUE:    q_data.kind = EV_ISSUE;
      CMD_COMPLETE: q_data.kind = (was_migrated && !row_hit) ? EV_COUNT : EV_NONE;
      default:      q_data.kind = EV_NONE;
    endcase
  end

endmodule

// ===== hdl/mtt_queue.sv =====
module mtt_queue #(
  parameter int unsigned DEPTH = mtt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mtt_pkg::ev_t push_data,
  output logic         full,
  input  logic         pop,
  output mtt_pkg::ev_t head,
  output logic         empty
);
  import mtt_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  ev_t                entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W_Q-1:0] fill;

  assign full  = (fill == CNT_W_Q'(DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W_Q'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W_Q'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/mtt_back.sv =====
module mtt_back (
  input  logic                clk,
  input  logic                rst,
  input  mtt_pkg::cfg_t       cfg,
  input  logic                thr_load,
  input  logic [15:0]         thr_load_value,
  input  logic                q_empty,
  input  mtt_pkg::ev_t        q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         threshold,
  output logic                adjusted,
  output logic signed [62:0]  benefit
);
  import mtt_pkg::*;

  localparam logic [THRESH_W-1:0] NEG_JUMP = THRESH_W'(3);

  // saturating threshold increase
  function automatic logic [THRESH_W-1:0] thr_up(input logic [THRESH_W-1:0] t,
                                                 input logic [THRESH_W-1:0] amt);
    logic [THRESH_W:0] s;
    s = {1'b0, t} + {1'b0, amt};
    return s[THRESH_W] ? '1 : s[THRESH_W-1:0];
  endfunction

  bk_state_t state;
  bk_state_t state_next;

  // tuning state
  logic [THRESH_W-1:0]     thresh;
  act_t                    action;
  logic signed [BEN_W-1:0] last_ben;
  logic [CYCLE_W-1:0]      last_adj_cycle;
  logic [CNT_W-1:0]        fast_dirty;
  logic [CNT_W-1:0]        fast_clean;
  logic [CNT_W-1:0]        slow_dirty;
  logic [CNT_W-1:0]        slow_clean;

  // issue work registers
  logic [CYCLE_W-1:0]      work_now;
  logic [COST_W-1:0]       work_cost;
  logic signed [CNT_W:0]   diff_dirty;
  logic signed [CNT_W:0]   diff_clean;
  logic signed [BEN_W-2:0] prod_dirty;
  logic signed [BEN_W-2:0] prod_clean;
  logic signed [BEN_W-1:0] prod_sum;
  logic signed [BEN_W-1:0] ben;

  logic                    out_free;
  logic [CYCLE_W-1:0]      elapsed;
  logic                    due;
  logic                    emit;
  logic                    emit_adj;
  logic                    count_en;
  logic                    load_work;
  logic [THRESH_W-1:0]     thresh_new;
  act_t                    action_new;

  assign out_free = !out_valid || out_ready;
  assign elapsed  = work_now - last_adj_cycle;
  assign due      = elapsed > {{(CYCLE_W-INTERVAL_W){1'b0}}, cfg.interval};

  // sequencer next state and controls
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_adj   = 1'b0;
    count_en   = 1'b0;
    load_work  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.kind == EV_ISSUE) begin
            q_pop      = 1'b1;
            load_work  = 1'b1;
            state_next = BK_CHECK;
          end else if (out_free) begin
            q_pop    = 1'b1;
            emit     = 1'b1;
            count_en = (q_head.kind == EV_COUNT);
          end
        end
      end
      BK_CHECK: begin
        if (due) begin
          state_next = BK_MUL;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_MUL:  state_next = BK_SUM;
      BK_SUM:  state_next = BK_COST;
      BK_COST: state_next = BK_ADJ;
      BK_ADJ: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_adj   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // hill-climbing step on the new benefit
  always_comb begin
    thresh_new = thresh;
    action_new = action;
    case (action)
      ACT_INC, ACT_DEC: begin
        if (ben < 0) begin
          thresh_new = thr_up(thresh_new, NEG_JUMP);
          action_new = ACT_INC;
        end
        if (ben > last_ben) begin
          if (action_new == ACT_INC) begin
            thresh_new = thr_up(thresh_new, THRESH_W'(1));
          end else if (thresh_new != '0) begin
            thresh_new = thresh_new - THRESH_W'(1);
          end
        end else begin
          if (action_new == ACT_INC) begin
            if (thresh_new != '0) begin
              thresh_new = thresh_new - THRESH_W'(1);
              action_new = ACT_DEC;
            end
          end else begin
            thresh_new = thr_up(thresh_new, THRESH_W'(1));
            action_new = ACT_INC;
          end
        end
      end
      default: begin
        if (ben > 0) begin
          action_new = ACT_DEC;
          if (thresh != '0) begin
            thresh_new = thresh - THRESH_W'(1);
          end
        end else begin
          action_new = ACT_INC;
          thresh_new = thr_up(thresh, THRESH_W'(1));
        end
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tuning state and miss counters
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh         <= '0;
      action         <= ACT_INIT;
      last_ben       <= '0;
      last_adj_cycle <= '0;
      fast_dirty     <= '0;
      fast_clean     <= '0;
      slow_dirty     <= '0;
      slow_clean     <= '0;
    end else begin
      if (thr_load) begin
        thresh <= thr_load_value;
      end else if (emit_adj) begin
        thresh <= thresh_new;
      end
      if (emit_adj) begin
        action         <= action_new;
        last_ben       <= ben;
        last_adj_cycle <= work_now;
      end
      if (count_en) begin
        case (q_head.sel)
          CNT_FAST_DIRTY: if (fast_dirty != '1) fast_dirty <= fast_dirty + CNT_W'(1);
          CNT_FAST_CLEAN: if (fast_clean != '1) fast_clean <= fast_clean + CNT_W'(1);
          CNT_SLOW_DIRTY: if (slow_dirty != '1) slow_dirty <= slow_dirty + CNT_W'(1);
          CNT_SLOW_CLEAN: if (slow_clean != '1) slow_clean <= slow_clean + CNT_W'(1);
          default: ;
        endcase
      end
    end
  end

  // benefit datapath: differences, products, sum, cost
  always_ff @(posedge clk) begin
    if (load_work) begin
      work_now  <= q_head.cycle_now;
      work_cost <= q_head.cost;
    end
    diff_dirty <= $signed({1'b0, fast_dirty}) - $signed({1'b0, slow_dirty});
    diff_clean <= $signed({1'b0, fast_clean}) - $signed({1'b0, slow_clean});
    prod_dirty <= diff_dirty * cfg.dirty_gap;
    prod_clean <= diff_clean * cfg.clean_gap;
    prod_sum   <= $signed({prod_dirty[BEN_W-2], prod_dirty})
                + $signed({prod_clean[BEN_W-2], prod_clean});
    ben        <= prod_sum - $signed({{(BEN_W-COST_W){1'b0}}, work_cost});
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      adjusted <= emit_adj;
      if (emit_adj) begin
        threshold <= thresh_new;
        benefit   <= {{(BENEFIT_W-BEN_W){ben[BEN_W-1]}}, ben};
      end else begin
        threshold <= thresh;
        benefit   <= {{(BENEFIT_W-BEN_W){last_ben[BEN_W-1]}}, last_ben};
      end
    end
  end

endmodule

// ===== hdl/migration_threshold_tuner.sv =====
// Hill-climbing tuner for the row-buffer-miss migration threshold of a hybrid
// fast/slow memory. Every accepted item gives exactly one result: the threshold
// after the item, an adjusted flag and the benefit of the latest adjustment.
// Items are classified on entry and wait in a QUEUE_DEPTH-entry queue, so the
// input keeps accepting while the result side stalls. In the back end a
// completion or ignored item retires once the result register is free, so
// completions run at one item per cycle while results are taken. An issue
// event holds the back end for the elapsed check if the interval has not
// passed, and for every step if it adjusts the threshold (elapsed check,
// counter differences, gap multiply, sum, cost subtract, threshold step).
// The user must write cfg_we/cfg_index/cfg_data only while the block is idle;
// not enforced. Writing the start threshold also loads the live one at once.
module migration_threshold_tuner #(
  parameter int unsigned QUEUE_DEPTH = mtt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [47:0]                      cycle_now,
  input  logic                             fast_media,
  input  logic                             row_hit,
  input  logic                             dirty_wb,
  input  logic                             was_migrated,
  input  logic [47:0]                      migration_cost,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      threshold,
  output logic                             adjusted,
  output logic signed [62:0]               benefit,
  input  logic                             cfg_we,
  input  logic [mtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mtt_pkg::*;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10000000);

  cfg_t cfg;
  logic thr_load;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  ev_t  q_in;
  ev_t  q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval  <= INTERVAL_RESET;
      cfg.dirty_gap <= '0;
      cfg.clean_gap <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INTERVAL:  cfg.interval  <= cfg_data[INTERVAL_W-1:0];
        REG_DIRTY_GAP: cfg.dirty_gap <= $signed(cfg_data[GAP_W-1:0]);
        REG_CLEAN_GAP: cfg.clean_gap <= $signed(cfg_data[GAP_W-1:0]);
        default: ;
      endcase
    end
  end

  // start threshold goes straight into the live threshold
  assign thr_load = cfg_we && (reg_idx_t'(cfg_index) == REG_START_THRESHOLD);

  mtt_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .cycle_now      (cycle_now),
    .fast_media     (fast_media),
    .row_hit        (row_hit),
    .dirty_wb       (dirty_wb),
    .was_migrated   (was_migrated),
    .migration_cost (migration_cost),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  mtt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mtt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .thr_load       (thr_load),
    .thr_load_value (cfg_data[THRESH_W-1:0]),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .threshold      (threshold),
    .adjusted       (adjusted),
    .benefit        (benefit)
  );

endmodule

// ===== tb/migration_threshold_tuner_tb.sv =====
module migration_threshold_tuner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtt_pkg::*;

  localparam int unsigned RUN_LIMIT   = 400_000;
  localparam int unsigned NEG_STEP    = 3;
  localparam logic [15:0] THRESH_TOP  = 16'hFFFF;
  localparam logic [31:0] COUNT_TOP   = 32'hFFFF_FFFF;
  localparam logic [39:0] INTERVAL_TOP = 40'hFF_FFFF_FFFF;

  // one memory event as seen on the input channel
  typedef struct {
    cmd_t        cmd;
    logic [47:0] cycle_now;
    logic        fast_media;
    logic        row_hit;
    logic        dirty_wb;
    logic        was_migrated;
    logic [47:0] migration_cost;
  } mem_event_t;

  // one tuner outcome as seen on the result channel
  typedef struct {
    logic [15:0]        threshold;
    logic               adjusted;
    logic signed [62:0] benefit;
  } tuner_outcome_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               cmd;
  logic [47:0]        cycle_now;
  logic               fast_media;
  logic               row_hit;
  logic               dirty_wb;
  logic               was_migrated;
  logic [47:0]        migration_cost;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        threshold;
  logic               adjusted;
  logic signed [62:0] benefit;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predicted tuner state and configuration
  logic [39:0]        interval_len;
  logic signed [15:0] dirty_gap_r;
  logic signed [15:0] clean_gap_r;
  logic [15:0]        thr;
  act_t               last_act;
  longint             last_gain;
  logic [47:0]        last_adj_cycle;
  logic [31:0]        miss_count [4];

  tuner_outcome_t pending_outcomes [$];
  tuner_outcome_t want;
  int unsigned    mismatches;
  int unsigned    cycle_count;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;

  migration_threshold_tuner dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .cycle_now      (cycle_now),
    .fast_media     (fast_media),
    .row_hit        (row_hit),
    .dirty_wb       (dirty_wb),
    .was_migrated   (was_migrated),
    .migration_cost (migration_cost),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .threshold      (threshold),
    .adjusted       (adjusted),
    .benefit        (benefit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("[migration_threshold_tuner] ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: threshold %0d adjusted %0b benefit %0d",
                 $time, threshold, adjusted, benefit);
        mismatches++;
      end else begin
        want = pending_outcomes[0];
        pending_outcomes.delete(0);
        if (threshold !== want.threshold) begin
          $display("%0t: threshold expected %0d actual %0d",
                   $time, want.threshold, threshold);
          mismatches++;
        end
        if (adjusted !== want.adjusted) begin
          $display("%0t: adjusted expected %0b actual %0b",
                   $time, want.adjusted, adjusted);
          mismatches++;
        end
        if (benefit !== want.benefit) begin
          $display("%0t: benefit expected %0d actual %0d",
                   $time, want.benefit, benefit);
          mismatches++;
        end
      end
    end
  end

  // threshold step up, sticking at the top
  function automatic logic [15:0] raise(input logic [15:0] t, input int unsigned amount);
    if (32'(t) + amount > 32'(THRESH_TOP))
      return THRESH_TOP;
    return t + 16'(amount);
  endfunction

  // hill-climbing step on a new benefit figure
  function automatic void retune(input logic [47:0] cost);
    longint gain;
    longint delta;
    gain = (longint'(miss_count[CNT_FAST_DIRTY]) - longint'(miss_count[CNT_SLOW_DIRTY]))
             * longint'(dirty_gap_r)
           + (longint'(miss_count[CNT_FAST_CLEAN]) - longint'(miss_count[CNT_SLOW_CLEAN]))
             * longint'(clean_gap_r)
           - longint'(cost);
    delta = gain - last_gain;
    if (last_act != ACT_INC && last_act != ACT_DEC) begin
      // first step away from the start value
      if (gain > 0) begin
        last_act = ACT_DEC;
        if (thr != 16'd0)
          thr = thr - 16'd1;
      end else begin
        last_act = ACT_INC;
        thr = raise(thr, 1);
      end
    end else begin
      // a loss forces a jump upwards first
      if (gain < 0) begin
        thr = raise(thr, NEG_STEP);
        last_act = ACT_INC;
      end
      if (delta > 0) begin
        if (last_act == ACT_INC)
          thr = raise(thr, 1);
        else if (thr != 16'd0)
          thr = thr - 16'd1;
      end else if (last_act == ACT_INC) begin
        if (thr != 16'd0) begin
          thr = thr - 16'd1;
          last_act = ACT_DEC;
        end
      end else begin
        thr = raise(thr, 1);
        last_act = ACT_INC;
      end
    end
    last_gain = gain;
  endfunction

  // predicted result of one accepted item
  function automatic tuner_outcome_t tuner_outcome(input mem_event_t ev);
    tuner_outcome_t r;
    logic [47:0]    elapsed;
    cnt_sel_t       sel;
    r.adjusted = 1'b0;
    if (ev.cmd == CMD_COMPLETE) begin
      if (ev.was_migrated && !ev.row_hit) begin
        sel = cnt_sel_t'({ev.fast_media, ev.dirty_wb});
        if (miss_count[sel] != COUNT_TOP)
          miss_count[sel] = miss_count[sel] + 32'd1;
      end
    end else begin
      elapsed = ev.cycle_now - last_adj_cycle;
      if (elapsed > {8'd0, interval_len}) begin
        retune(ev.migration_cost);
        last_adj_cycle = ev.cycle_now;
        r.adjusted = 1'b1;
      end
    end
    r.threshold = thr;
    r.benefit   = last_gain[62:0];
    return r;
  endfunction

  function automatic mem_event_t completion_event(input bit fast, input bit dirty,
                                                  input bit hit, input bit migrated);
    mem_event_t ev;
    ev.cmd            = CMD_COMPLETE;
    ev.cycle_now      = 48'({$urandom(), $urandom()});
    ev.migration_cost = 48'({$urandom(), $urandom()});
    ev.fast_media     = fast;
    ev.dirty_wb       = dirty;
    ev.row_hit        = hit;
    ev.was_migrated   = migrated;
    return ev;
  endfunction

  function automatic mem_event_t issue_event(input logic [47:0] at, input logic [47:0] cost);
    mem_event_t ev;
    ev.cmd            = CMD_ISSUE;
    ev.cycle_now      = at;
    ev.migration_cost = cost;
    ev.fast_media     = 1'($urandom_range(1));
    ev.dirty_wb       = 1'($urandom_range(1));
    ev.row_hit        = 1'($urandom_range(1));
    ev.was_migrated   = 1'($urandom_range(1));
    return ev;
  endfunction

  // mostly counted misses and issues around the interval edge, some noise
  function automatic mem_event_t random_event();
    logic [47:0] span;
    logic [47:0] cost;
    int unsigned pick;
    pick = $urandom_range(99);
    span = {8'd0, interval_len};
    if (pick < 55)
      return completion_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                              $urandom_range(9) == 0, $urandom_range(9) != 0);
    if (pick < 90) begin
      case ($urandom_range(4))
        0: ;                                         // exactly one interval: held
        1: span = span - 48'($urandom_range(1, 4));  // short of the interval
        default: span = span + 48'($urandom_range(1, 64));
      endcase
      case ($urandom_range(9))
        0: cost = 48'd0;
        1: cost = 48'({$urandom(), $urandom()});
        default: cost = 48'($urandom_range(0, 2_000_000));
      endcase
      return issue_event(last_adj_cycle + span, cost);
    end
    return issue_event(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
  endfunction

  // present one item, hold it until taken, then predict its result
  task automatic send_event(input mem_event_t ev);
    int unsigned gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= ev.cmd;
    cycle_now      <= ev.cycle_now;
    fast_media     <= ev.fast_media;
    row_hit        <= ev.row_hit;
    dirty_wb       <= ev.dirty_wb;
    was_migrated   <= ev.was_migrated;
    migration_cost <= ev.migration_cost;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_outcomes.insert(pending_outcomes.size(), tuner_outcome(ev));
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [39:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_INTERVAL:        interval_len = value;
      REG_DIRTY_GAP:       dirty_gap_r  = value[15:0];
      REG_CLEAN_GAP:       clean_gap_r  = value[15:0];
      REG_START_THRESHOLD: thr          = value[15:0];
      default: ;
    endcase
  endtask

  // upper bits of a narrow register are junk and must be dropped
  function automatic logic [39:0] narrow(input logic [15:0] v);
    return {24'($urandom()), v};
  endfunction

  task automatic run_random(input int unsigned count);
    mem_event_t  ev;
    int unsigned taken;
    taken = 0;
    while (taken < count) begin
      ev = random_event();
      send_event(ev);
      if (ev.cmd == CMD_ISSUE || (ev.was_migrated && !ev.row_hit))
        taken++;
    end
    settle();
  endtask

  // defaults out of reset, one counted and two uncounted completions, issue right on the interval
  task automatic test_reset_values();
    send_event(completion_event(1'b1, 1'b1, 1'b0, 1'b1));
    send_event(completion_event(1'b0, 1'b1, 1'b1, 1'b1));
    send_event(completion_event(1'b1, 1'b0, 1'b0, 1'b0));
    send_event(issue_event(48'd10_000_000, 48'd123));
    settle();
  endtask

  // first adjustment with a gain, threshold already at zero
  task automatic test_first_step();
    write_reg(REG_DIRTY_GAP, narrow(16'd7));
    send_event(issue_event(48'd10_000_001, 48'd0));
    settle();
  endtask

  // extreme gaps, all four counters, loss jump into the ceiling
  task automatic test_gap_extremes();
    write_reg(REG_INTERVAL, 40'd1);
    write_reg(REG_DIRTY_GAP, narrow(16'h7FFF));
    write_reg(REG_CLEAN_GAP, narrow(16'h8000));
    write_reg(REG_START_THRESHOLD, narrow(THRESH_TOP));
    send_event(completion_event(1'b1, 1'b0, 1'b0, 1'b1));
    send_event(completion_event(1'b0, 1'b1, 1'b0, 1'b1));
    send_event(completion_event(1'b0, 1'b0, 1'b0, 1'b1));
    send_event(completion_event(1'b0, 1'b0, 1'b0, 1'b1));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'd0));
    send_event(issue_event(last_adj_cycle + 48'd1, 48'd0));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'hFFFF_FFFF_FFFF));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'd0));
    settle();
  endtask

  // decrements with the threshold at zero in both directions of travel
  task automatic test_zero_floor();
    write_reg(REG_START_THRESHOLD, narrow(16'd0));
    send_event(completion_event(1'b1, 1'b1, 1'b0, 1'b1));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'd0));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'd0));
    settle();
    write_reg(REG_START_THRESHOLD, narrow(16'd0));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'd0));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'd0));
    settle();
  endtask

  // single step upwards from the top value
  task automatic test_ceiling();
    write_reg(REG_START_THRESHOLD, narrow(THRESH_TOP));
    send_event(completion_event(1'b1, 1'b1, 1'b0, 1'b1));
    send_event(issue_event(last_adj_cycle + 48'd2, 48'd0));
    settle();
  endtask

  // longest interval, then elapsed time across the cycle counter wrap
  task automatic test_interval_wrap();
    write_reg(REG_INTERVAL, INTERVAL_TOP);
    send_event(issue_event(last_adj_cycle + {8'd0, INTERVAL_TOP}, 48'd5));
    send_event(issue_event(last_adj_cycle + {8'd0, INTERVAL_TOP} + 48'd1, 48'd5));
    settle();
    write_reg(REG_INTERVAL, 40'd1);
    send_event(issue_event(48'hFFFF_FFFF_FFFE, 48'd9));
    send_event(issue_event(48'd0, 48'd0));
    send_event(issue_event(48'd1, 48'd0));
    settle();
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 30;
    recv_idle_pct = 60;
    write_reg(REG_INTERVAL, 40'($urandom_range(1, 40)));
    write_reg(REG_DIRTY_GAP, narrow(16'($urandom())));
    write_reg(REG_CLEAN_GAP, narrow(16'($urandom())));
    write_reg(REG_START_THRESHOLD, narrow(16'($urandom())));
    run_random(135);
  endtask

  task automatic test_random_receiver_idle();
    send_idle_pct = 60;
    recv_idle_pct = 30;
    write_reg(REG_INTERVAL, 40'($urandom_range(100, 5000)));
    write_reg(REG_DIRTY_GAP, narrow(16'h8000));
    write_reg(REG_CLEAN_GAP, narrow(16'h7FFF));
    write_reg(REG_START_THRESHOLD, narrow(16'd65533));
    run_random(135);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_INTERVAL, 40'd1);
    write_reg(REG_DIRTY_GAP, narrow(16'($urandom())));
    write_reg(REG_CLEAN_GAP, narrow(16'($urandom())));
    write_reg(REG_START_THRESHOLD, narrow(16'd0));
    run_random(135);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = CMD_COMPLETE;
    cycle_now      = '0;
    fast_media     = 1'b0;
    row_hit        = 1'b0;
    dirty_wb       = 1'b0;
    was_migrated   = 1'b0;
    migration_cost = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_INTERVAL;
    cfg_data       = '0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;

    // tuner state after reset
    interval_len   = 40'd10_000_000;
    dirty_gap_r    = '0;
    clean_gap_r    = '0;
    thr            = '0;
    last_act       = ACT_INIT;
    last_gain      = 0;
    last_adj_cycle = '0;
    foreach (miss_count[i])
      miss_count[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_first_step();
    test_gap_extremes();
    test_zero_floor();
    test_ceiling();
    test_interval_wrap();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_full_rate();

    if (mismatches == 0)
      $display("[migration_threshold_tuner] OK");
    else
      $display("[migration_threshold_tuner] ERROR");
    $finish;
  end

endmodule
